### design/est_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the Euclidean step sequencer.
package est_pkg;

    // Fixed field widths
    localparam int STEP_W  = 7;   // step_count, onset_count, fill_every
    localparam int POS_W   = 6;   // ring position, rotation, cycle phase
    localparam int PITCH_W = 7;
    localparam int VEL_W   = 7;
    localparam int NOTE_W  = 8;   // stored pool entry, signed, negative = rest
    localparam int LEN_W   = 8;   // pool length registers
    localparam int SLOT_W  = 7;   // entry_index

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Ring size limit and default pool depth
    localparam int MAX_STEPS      = 64;
    localparam int POOL_DEPTH_DEF = 128;

    // Register reset values
    localparam logic [STEP_W-1:0] STEP_COUNT_RST  = 7'd16;
    localparam logic [STEP_W-1:0] ONSET_COUNT_RST = 7'd4;
    localparam logic [POS_W-1:0]  ROTATION_RST    = 6'd0;
    localparam logic [STEP_W-1:0] FILL_EVERY_RST  = 7'd0;
    localparam logic [VEL_W-1:0]  VELOCITY_RST    = 7'd96;
    localparam logic [LEN_W-1:0]  MAIN_LEN_RST    = 8'd1;
    localparam logic [LEN_W-1:0]  FILL_LEN_RST    = 8'd1;

    // Request operations
    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_WRITE_MAIN = 2'd1,
        OP_WRITE_FILL = 2'd2
    } op_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_COUNT  = 3'd0,
        REG_ONSET_COUNT = 3'd1,
        REG_ROTATION    = 3'd2,
        REG_FILL_EVERY  = 3'd3,
        REG_VELOCITY    = 3'd4,
        REG_MAIN_LEN    = 3'd5,
        REG_FILL_LEN    = 3'd6
    } reg_idx_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_KMOD,       // k = (pos + rotation) mod steps, bit serial
        S_MMUL,       // (k * onsets) mod steps, bit serial
        S_MAIN_MOD,   // main index mod main length
        S_FILL_MOD,   // fill index mod fill length
        S_READ,       // pool read issued
        S_DATA,       // pool data back, indexes advance
        S_FINISH      // result out, ring position and phase advance
    } state_t;

endpackage

### design/est_ram.sv
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read.
module est_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### design/euclidean_step_sequencer.sv
`timescale 1ns / 1ps
// Top level of the Euclidean step sequencer: config registers, serial datapath, note pools.
//
// Usage: requests enter on in_valid/in_ready. A request is a step tick or a write of
// one entry of the main or fill note pool. Each tick may produce one note on
// out_valid/out_ready; writes and unknown operations produce nothing. Configuration
// registers are written on cfg_valid/cfg_ready (always ready) with cfg_index/cfg_data;
// the user must write them only while the block is idle; the block does not enforce it.
// Operation: a pool write is done as it is accepted. A tick with the transport
// stopped or with no onsets goes from acceptance straight to the finish state. Else
// the shared bit-serial remainder unit reduces the rotated position and then forms
// the modular product (skipped when every step is an onset), then reduces the main
// pool index and, on a fill cycle, the fill pool index; the pool read, pool data
// and finish states follow. A step that is no onset ends after the product.
// in_ready is high only while the sequencer is idle; one tick is worked at a time.
// The result sits in an output register, so the next request is taken while a note
// still waits; a tick with a note to emit that finds that register full holds in its
// finish state until the receiver takes the waiting note.
// Reset clears the ring position, pool indexes and cycle phase and loads the register
// defaults. Pool contents are not cleared; there is no clearing pass.
module euclidean_step_sequencer #(
    parameter int POOL_DEPTH = est_pkg::POOL_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [est_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [est_pkg::CFG_DATA_W-1:0]   cfg_data,
    // request channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       operation,
    input  logic                             transport_running,
    input  logic [est_pkg::SLOT_W-1:0]       entry_index,
    input  logic signed [est_pkg::NOTE_W-1:0] entry_note,
    // note channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [est_pkg::PITCH_W-1:0]      note_number,
    output logic [est_pkg::VEL_W-1:0]        note_velocity,
    output logic                             from_fill,
    output logic [est_pkg::POS_W-1:0]        step_position
);

    import est_pkg::*;

    localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;   // pool index
    localparam int LW = $clog2(POOL_DEPTH + 1);                       // clamped length
    localparam int RW = (LW > STEP_W) ? LW : STEP_W;                  // remainder/divisor
    localparam int DW = (IW > STEP_W) ? IW : STEP_W;                  // dividend shifter
    localparam int CW = $clog2(DW + 1);                               // bit counter

    // configuration registers
    logic [STEP_W-1:0] step_count_reg;
    logic [STEP_W-1:0] onset_count_reg;
    logic [POS_W-1:0]  rotation_reg;
    logic [STEP_W-1:0] fill_every_reg;
    logic [VEL_W-1:0]  velocity_reg;
    logic [LEN_W-1:0]  main_len_reg;
    logic [LEN_W-1:0]  fill_len_reg;

    // control and datapath registers
    state_t            state_reg, state_next;
    logic [POS_W-1:0]  ring_pos_reg, ring_pos_next;
    logic [POS_W-1:0]  cycle_phase_reg, cycle_phase_next;
    logic [IW-1:0]     main_index_reg, main_index_next;
    logic [IW-1:0]     fill_index_reg, fill_index_next;
    logic [RW-1:0]     rem_reg, rem_next;
    logic [RW-1:0]     div_reg, div_next;
    logic [DW-1:0]     dvd_reg, dvd_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [POS_W-1:0]  k_reg, k_next;
    logic [IW-1:0]     mmod_reg, mmod_next;
    logic [IW-1:0]     fmod_reg, fmod_next;
    logic              emit_reg, emit_next;
    logic [PITCH_W-1:0] pitch_reg, pitch_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [PITCH_W-1:0] out_note_reg, out_note_next;
    logic [VEL_W-1:0]   out_vel_reg, out_vel_next;
    logic               out_fill_reg, out_fill_next;
    logic [POS_W-1:0]   out_pos_reg, out_pos_next;

    // derived configuration
    logic [STEP_W-1:0] steps_c;
    logic [POS_W-1:0]  pos_c;
    logic [LW-1:0]     mlen_c;
    logic [LW-1:0]     flen_c;
    logic              on_fill_c;
    logic              act_len_ok;
    logic              fills_zero;
    logic              fills_all;
    logic [STEP_W-1:0] kin_c;

    // serial remainder unit
    logic              dvd_msb;
    logic              trial_bit;
    logic [RW:0]       trial;
    logic [RW:0]       div_ext;
    logic [RW-1:0]     r_step;
    logic [RW:0]       addend;
    logic [RW:0]       sum;
    logic [RW-1:0]     r_mul;
    logic [RW-1:0]     rem_step;
    logic              last_bit;

    // misc
    logic              start_main;
    logic              finish_go;
    logic              slot_ok;
    logic              main_we;
    logic              fill_we;
    logic [IW-1:0]     wr_addr;
    logic [NOTE_W-1:0] main_rdata;
    logic [NOTE_W-1:0] fill_rdata;
    logic [NOTE_W-1:0] note_sel;
    logic [LW-1:0]     m_inc;
    logic [LW-1:0]     f_inc;
    logic [IW-1:0]     main_adv;
    logic [IW-1:0]     fill_adv;
    logic [STEP_W-1:0] pos_inc;
    logic              ring_wrap;
    logic [STEP_W-1:0] phase_inc;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg  <= STEP_COUNT_RST;
            onset_count_reg <= ONSET_COUNT_RST;
            rotation_reg    <= ROTATION_RST;
            fill_every_reg  <= FILL_EVERY_RST;
            velocity_reg    <= VELOCITY_RST;
            main_len_reg    <= MAIN_LEN_RST;
            fill_len_reg    <= FILL_LEN_RST;
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_STEP_COUNT:  step_count_reg  <= cfg_data[STEP_W-1:0];
                REG_ONSET_COUNT: onset_count_reg <= cfg_data[STEP_W-1:0];
                REG_ROTATION:    rotation_reg    <= cfg_data[POS_W-1:0];
                REG_FILL_EVERY:  fill_every_reg  <= cfg_data[STEP_W-1:0];
                REG_VELOCITY:    velocity_reg    <= cfg_data[VEL_W-1:0];
                REG_MAIN_LEN:    main_len_reg    <= cfg_data[LEN_W-1:0];
                REG_FILL_LEN:    fill_len_reg    <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped configuration and per-tick decisions
    always_comb
    begin
        if (step_count_reg == '0)
            steps_c = STEP_W'(1);
        else if (step_count_reg > STEP_W'(MAX_STEPS))
            steps_c = STEP_W'(MAX_STEPS);
        else
            steps_c = step_count_reg;

        pos_c  = ({1'b0, ring_pos_reg} >= steps_c) ? '0 : ring_pos_reg;
        kin_c  = {1'b0, pos_c} + {1'b0, rotation_reg};
        mlen_c = (32'(main_len_reg) > POOL_DEPTH) ? LW'(POOL_DEPTH) : LW'(main_len_reg);
        flen_c = (32'(fill_len_reg) > POOL_DEPTH) ? LW'(POOL_DEPTH) : LW'(fill_len_reg);

        on_fill_c  = (fill_every_reg != '0) && (flen_c != '0) &&
                     ({1'b0, cycle_phase_reg} == (fill_every_reg - STEP_W'(1)));
        act_len_ok = on_fill_c || (mlen_c != '0);
        fills_zero = (onset_count_reg == '0);
        fills_all  = (onset_count_reg >= steps_c);
    end

    // one restoring step per cycle; in the product phase also a modular add of k
    always_comb
    begin
        dvd_msb   = dvd_reg[DW-1];
        trial_bit = (state_reg == S_MMUL) ? 1'b0 : dvd_msb;
        trial     = {rem_reg, trial_bit};
        div_ext   = {1'b0, div_reg};
        r_step    = (trial >= div_ext) ? RW'(trial - div_ext) : RW'(trial);
        addend    = ((state_reg == S_MMUL) && dvd_msb) ? (RW + 1)'(k_reg) : '0;
        sum       = {1'b0, r_step} + addend;
        r_mul     = (sum >= div_ext) ? RW'(sum - div_ext) : RW'(sum);
        rem_step  = (state_reg == S_MMUL) ? r_mul : r_step;
        last_bit  = (cnt_reg == CW'(1));
    end

    // index advance, ring advance
    always_comb
    begin
        m_inc     = LW'(mmod_reg) + LW'(1);
        f_inc     = LW'(fmod_reg) + LW'(1);
        main_adv  = (m_inc >= mlen_c) ? '0 : IW'(m_inc);
        fill_adv  = (f_inc >= flen_c) ? '0 : IW'(f_inc);
        note_sel  = on_fill_c ? fill_rdata : main_rdata;
        pos_inc   = {1'b0, ring_pos_reg} + STEP_W'(1);
        ring_wrap = (pos_inc >= steps_c);
        phase_inc = {1'b0, cycle_phase_reg} + STEP_W'(1);
        finish_go = !(emit_reg && out_valid_reg && !out_ready);
    end

    // pool write decode
    always_comb
    begin
        slot_ok = (32'(entry_index) < POOL_DEPTH);
        wr_addr = IW'(entry_index);
        main_we = 1'b0;
        fill_we = 1'b0;
        if ((state_reg == S_IDLE) && in_valid && slot_ok)
        begin
            unique case (op_t'(operation))
                OP_WRITE_MAIN: main_we = 1'b1;
                OP_WRITE_FILL: fill_we = 1'b1;
                default: ;
            endcase
        end
    end

    // sequencer: next state and datapath
    always_comb
    begin
        state_next       = state_reg;
        ring_pos_next    = ring_pos_reg;
        cycle_phase_next = cycle_phase_reg;
        main_index_next  = main_index_reg;
        fill_index_next  = fill_index_reg;
        rem_next         = rem_reg;
        div_next         = div_reg;
        dvd_next         = dvd_reg;
        cnt_next         = cnt_reg;
        k_next           = k_reg;
        mmod_next        = mmod_reg;
        fmod_next        = fmod_reg;
        emit_next        = emit_reg;
        pitch_next       = pitch_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_note_next    = out_note_reg;
        out_vel_next     = out_vel_reg;
        out_fill_next    = out_fill_reg;
        out_pos_next     = out_pos_reg;
        start_main       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && (op_t'(operation) == OP_TICK))
                begin
                    ring_pos_next = pos_c;
                    emit_next     = 1'b0;
                    if (!transport_running)
                    begin
                        state_next = S_FINISH;
                    end
                    else if (fills_zero || fills_all)
                    begin
                        if (!fills_zero && act_len_ok)
                            start_main = 1'b1;
                        else
                            state_next = S_FINISH;
                    end
                    else
                    begin
                        rem_next   = '0;
                        div_next   = RW'(steps_c);
                        dvd_next   = DW'(kin_c) << (DW - STEP_W);
                        cnt_next   = CW'(STEP_W);
                        state_next = S_KMOD;
                    end
                end
            end

            S_KMOD:
            begin
                rem_next = rem_step;
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg - CW'(1);
                if (last_bit)
                begin
                    k_next     = POS_W'(rem_step);
                    rem_next   = '0;
                    dvd_next   = DW'(onset_count_reg) << (DW - STEP_W);
                    cnt_next   = CW'(STEP_W);
                    state_next = S_MMUL;
                end
            end

            S_MMUL:
            begin
                rem_next = rem_step;
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg - CW'(1);
                if (last_bit)
                begin
                    if ((rem_step < RW'(onset_count_reg)) && act_len_ok)
                        start_main = 1'b1;
                    else
                        state_next = S_FINISH;
                end
            end

            S_MAIN_MOD:
            begin
                rem_next = rem_step;
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg - CW'(1);
                if (last_bit)
                begin
                    mmod_next = IW'(rem_step);
                    if (on_fill_c)
                    begin
                        rem_next   = '0;
                        div_next   = RW'(flen_c);
                        dvd_next   = DW'(fill_index_reg) << (DW - IW);
                        cnt_next   = CW'(IW);
                        state_next = S_FILL_MOD;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end

            S_FILL_MOD:
            begin
                rem_next = rem_step;
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg - CW'(1);
                if (last_bit)
                begin
                    fmod_next  = IW'(rem_step);
                    state_next = S_READ;
                end
            end

            S_READ:
            begin
                state_next = S_DATA;
            end

            S_DATA:
            begin
                // a rest takes its turn but plays nothing
                emit_next  = !note_sel[NOTE_W-1];
                pitch_next = note_sel[PITCH_W-1:0];
                if (mlen_c != '0)
                    main_index_next = main_adv;
                if (on_fill_c)
                    fill_index_next = fill_adv;
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (finish_go)
                begin
                    if (emit_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_note_next  = pitch_reg;
                        out_vel_next   = velocity_reg;
                        out_fill_next  = on_fill_c;
                        out_pos_next   = ring_pos_reg;
                    end
                    if (ring_wrap)
                    begin
                        ring_pos_next    = '0;
                        cycle_phase_next = (phase_inc >= fill_every_reg) ? '0
                                                                         : POS_W'(phase_inc);
                    end
                    else
                    begin
                        ring_pos_next = POS_W'(pos_inc);
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // load the remainder unit with the main index
        if (start_main)
        begin
            rem_next   = '0;
            div_next   = RW'(mlen_c);
            dvd_next   = DW'(main_index_reg) << (DW - IW);
            cnt_next   = CW'(IW);
            state_next = S_MAIN_MOD;
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_pos_reg    <= '0;
            cycle_phase_reg <= '0;
            main_index_reg  <= '0;
            fill_index_reg  <= '0;
            rem_reg         <= '0;
            div_reg         <= '0;
            dvd_reg         <= '0;
            cnt_reg         <= '0;
            k_reg           <= '0;
            mmod_reg        <= '0;
            fmod_reg        <= '0;
            emit_reg        <= 1'b0;
            pitch_reg       <= '0;
            out_valid_reg   <= 1'b0;
            out_note_reg    <= '0;
            out_vel_reg     <= '0;
            out_fill_reg    <= 1'b0;
            out_pos_reg     <= '0;
        end
        else
        begin
            ring_pos_reg    <= ring_pos_next;
            cycle_phase_reg <= cycle_phase_next;
            main_index_reg  <= main_index_next;
            fill_index_reg  <= fill_index_next;
            rem_reg         <= rem_next;
            div_reg         <= div_next;
            dvd_reg         <= dvd_next;
            cnt_reg         <= cnt_next;
            k_reg           <= k_next;
            mmod_reg        <= mmod_next;
            fmod_reg        <= fmod_next;
            emit_reg        <= emit_next;
            pitch_reg       <= pitch_next;
            out_valid_reg   <= out_valid_next;
            out_note_reg    <= out_note_next;
            out_vel_reg     <= out_vel_next;
            out_fill_reg    <= out_fill_next;
            out_pos_reg     <= out_pos_next;
        end
    end

    // note pools
    est_ram #(
        .WIDTH (NOTE_W),
        .DEPTH (POOL_DEPTH)
    ) u_main_pool (
        .clk     (clk),
        .wr_en   (main_we),
        .wr_addr (wr_addr),
        .wr_data (entry_note),
        .rd_addr (mmod_reg),
        .rd_data (main_rdata)
    );

    est_ram #(
        .WIDTH (NOTE_W),
        .DEPTH (POOL_DEPTH)
    ) u_fill_pool (
        .clk     (clk),
        .wr_en   (fill_we),
        .wr_addr (wr_addr),
        .wr_data (entry_note),
        .rd_addr (fmod_reg),
        .rd_data (fill_rdata)
    );

    assign out_valid     = out_valid_reg;
    assign note_number   = out_note_reg;
    assign note_velocity = out_vel_reg;
    assign from_fill     = out_fill_reg;
    assign step_position = out_pos_reg;

    // remainder stays reduced while the serial unit runs
    a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_KMOD) || (state_reg == S_MMUL) ||
         (state_reg == S_MAIN_MOD) || (state_reg == S_FILL_MOD)) && (div_reg != '0)
        |-> (rem_reg < div_reg))
        else $error("remainder not below divisor");

    // after an advance the main index lies inside the pool
    a_main_idx: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg == S_DATA) && (mlen_c != '0))
        |-> (LW'(main_index_reg) < mlen_c))
        else $error("main index past pool length");

    // ring position stays below the step count it was advanced against
    a_ring_pos: assert property (@(posedge clk) disable iff (!rst_n)
        $past((state_reg == S_FINISH) && finish_go)
        |-> ({1'b0, ring_pos_reg} < $past(steps_c)))
        else $error("ring position past step count");

    // a note only appears as a tick completes
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past((state_reg == S_FINISH) && emit_reg))
        else $error("note emitted outside tick completion");

    // a tick never overwrites a note still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) && emit_reg && out_valid_reg && !out_ready
        |=> (state_reg == S_FINISH))
        else $error("waiting note overwritten");

endmodule
